// File: sv/itrt_pkg.sv
// Shared types, constants and helpers for the integer to radix text converter.
// No dependencies; every module of the block imports this package.
package itrt_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int MAX_DIGITS   = 32;
  localparam int IN_W         = 32;
  localparam int BASE_W       = 6;
  localparam int CHAR_W       = 8;
  localparam int DIGIT_W      = 6;
  localparam int BASE_MIN     = 2;
  localparam int BASE_MAX     = 36;
  localparam int DEC_DIGITS   = 10;

  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_CYC = 8;
  localparam int DIV_CYCLES   = (VALUE_WIDTH + BITS_PER_CYC - 1) / BITS_PER_CYC;
  localparam int WORK_W       = DIV_CYCLES * BITS_PER_CYC;
  localparam int SUB_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  // One classified number as it travels from the front to the back.
  typedef struct packed {
    logic                   bad;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic [BASE_W-1:0]      base;
  } itrt_desc_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (dw < CHAR_W'(DEC_DIGITS)) begin
      return CH_ZERO + dw;
    end
    return CH_A + dw - CHAR_W'(DEC_DIGITS);
  endfunction

endpackage

// File: sv/integer_to_radix_text.sv
// Top level of the integer to radix text converter: front end, queue and back end.
// Depends on itrt_pkg, itrt_front and itrt_back.
//
//   channel | ports                                           | beat
//   in      | in_valid/in_ready, in_kind, in_value, in_base   | one number
//   out     | out_valid/out_ready, out_text_char, out_last,   | one character
//           | out_bad_base                                    |
//
// A number is loaded from the queue and divided by the base one digit per pass (8
// quotient bits a cycle over a 32-bit word); its characters are then sent one per
// cycle while the output accepts them. A bad base skips the divider.
// The front queues up to two numbers while the back works.
// Reset is synchronous and active low; it empties the queue and the output register.
// A stalled output holds its beat, and the back end waits for the slot.
module integer_to_radix_text (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [itrt_pkg::IN_W-1:0]    in_value,
  input  logic [itrt_pkg::BASE_W-1:0]  in_base,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [itrt_pkg::CHAR_W-1:0]  out_text_char,
  output logic                         out_last,
  output logic                         out_bad_base
);
  import itrt_pkg::*;

  logic       q_valid;
  logic       q_pop;
  itrt_desc_t q_desc;

  itrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .in_value (in_value),
    .in_base  (in_base),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_desc   (q_desc)
  );

  itrt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_desc        (q_desc),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last      (out_last),
    .out_bad_base  (out_bad_base)
  );

endmodule

// File: sv/itrt_front.sv
// Front end: accepts input beats, checks the base, takes the magnitude and
// queues the result in a two-entry buffer. Depends on itrt_pkg.
module itrt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic [itrt_pkg::IN_W-1:0]   in_value,
  input  logic [itrt_pkg::BASE_W-1:0] in_base,
  output logic                      q_valid,
  input  logic                      q_pop,
  output itrt_pkg::itrt_desc_t      q_desc
);
  import itrt_pkg::*;

  itrt_desc_t             entry_r [2];
  logic                   wr_ptr_r, wr_ptr_nxt;
  logic                   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]             count_r, count_nxt;
  logic                   push;
  logic                   pop;
  logic [VALUE_WIDTH-1:0] raw;
  itrt_desc_t             desc;

  always_comb begin
    raw       = VALUE_WIDTH'(in_value);
    desc.base = in_base;
    desc.bad  = !(in_base inside {[BASE_MIN:BASE_MAX]});
    desc.neg  = in_kind & raw[VALUE_WIDTH-1];
    // The signed minimum negates to itself, which read unsigned is its magnitude.
    desc.mag  = desc.neg ? (~raw + VALUE_WIDTH'(1)) : raw;
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_desc   = entry_r[rd_ptr_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_pop & q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= desc;
    end
  end

endmodule

// File: sv/itrt_back.sv
// Back end: divides the magnitude by the base a few bits per cycle, stacks the
// digits and sends the characters out most significant first. Depends on itrt_pkg.
module itrt_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  itrt_pkg::itrt_desc_t         q_desc,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [itrt_pkg::CHAR_W-1:0]  out_text_char,
  output logic                         out_last,
  output logic                         out_bad_base
);
  import itrt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic               neg_r, neg_nxt;
  logic               bad_r, bad_nxt;
  logic [WORK_W-1:0]  work_r, work_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0] stack_r [MAX_DIGITS];
  logic               push;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic               last_r, last_nxt;
  logic               badf_r, badf_nxt;

  logic [WORK_W-1:0]  w;
  logic [DIGIT_W-1:0] r;
  logic [DIGIT_W:0]   t;
  logic               qb;
  logic               slot_free;
  logic [CNT_W-1:0]   top;

  // Restoring long division, BITS_PER_CYC quotient bits per cycle.
  always_comb begin
    w = work_r;
    r = rem_r;
    t = '0;
    qb = 1'b0;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      t  = {r, w[WORK_W-1]};
      qb = (t >= (DIGIT_W+1)'(base_r));
      if (qb) begin
        t = t - (DIGIT_W+1)'(base_r);
      end
      r = t[DIGIT_W-1:0];
      w = {w[WORK_W-2:0], qb};
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign top       = cnt_r - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    bad_nxt       = bad_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    sub_nxt       = sub_r;
    cnt_nxt       = cnt_r;
    push          = 1'b0;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    char_nxt      = char_r;
    last_nxt      = last_r;
    badf_nxt      = badf_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          base_nxt = q_desc.base;
          neg_nxt  = q_desc.neg;
          bad_nxt  = q_desc.bad;
          work_nxt = WORK_W'(q_desc.mag);
          rem_nxt  = '0;
          sub_nxt  = '0;
          cnt_nxt  = '0;
          state_nxt = q_desc.bad ? S_EMIT : S_DIV;
        end
      end
      S_DIV: begin
        work_nxt = w;
        rem_nxt  = r;
        sub_nxt  = sub_r + SUB_W'(1);
        if (sub_r == SUB_W'(DIV_CYCLES - 1)) begin
          // A full pass leaves the quotient in w and the digit in r.
          push    = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          rem_nxt = '0;
          sub_nxt = '0;
          if (w == '0 || cnt_r == CNT_W'(MAX_DIGITS - 1)) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (bad_r) begin
            char_nxt  = CH_NUL;
            last_nxt  = 1'b1;
            badf_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (neg_r) begin
            char_nxt = CH_MINUS;
            last_nxt = 1'b0;
            badf_nxt = 1'b0;
            neg_nxt  = 1'b0;
          end else begin
            char_nxt = digit_char(stack_r[top[IDX_W-1:0]]);
            last_nxt = (cnt_r == CNT_W'(1));
            badf_nxt = 1'b0;
            cnt_nxt  = top;
            if (cnt_r == CNT_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    neg_r  <= neg_nxt;
    bad_r  <= bad_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    sub_r  <= sub_nxt;
    cnt_r  <= cnt_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    badf_r <= badf_nxt;
    if (push) begin
      stack_r[cnt_r[IDX_W-1:0]] <= r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = char_r;
  assign out_last      = last_r;
  assign out_bad_base  = badf_r;

endmodule
